// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers used by the timer queue top level.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define TQ_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("timer queue assertion failed");

`define TQ_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("timer queue forbidden condition");

`else

`define TQ_ASSERT(label, clk, rst_n, prop)

`define TQ_ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

// ===== rtl/core/tq_pkg.sv =====
// ----------------------------------------------------------------------------
// Timer queue package
// Payload structs, operation and result codes, and default parameters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tq_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int TIME_BITS_DEF  = 32;

    localparam logic [31:0] MIN_DELAY_RST = 32'd100;

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_CANCEL = 2'd2;

    localparam logic [2:0] KIND_ADDED     = 3'd0;
    localparam logic [2:0] KIND_FULL      = 3'd1;
    localparam logic [2:0] KIND_CANCELLED = 3'd2;
    localparam logic [2:0] KIND_NO_MATCH  = 3'd3;
    localparam logic [2:0] KIND_EXPIRED   = 3'd4;
    localparam logic [2:0] KIND_TICK_DONE = 3'd5;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] now_time;
        logic [31:0] expire_time;
        logic [31:0] repeat_interval;
        logic [3:0]  cancel_slot;
        logic [15:0] cancel_sequence;
    } t_item;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] now_time;
        logic [31:0] expire_time;
        logic [31:0] repeat_interval;
        logic [3:0]  cancel_slot;
        logic [15:0] cancel_sequence;
    } t_cmd;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  slot;
        logic [15:0] sequence_res;
        logic        earliest_changed;
        logic        has_next;
        logic [31:0] next_delay;
        logic        last;
    } t_result;

endpackage

// ===== rtl/core/tq_front.sv =====
// ----------------------------------------------------------------------------
// Timer queue front end
// Accepts input transactions, decodes the mode and queues commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tq_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tq_pkg::t_item i_item,
    output logic          o_full,
    input  logic          i_cmd_pop,
    output logic          o_cmd_valid,
    output tq_pkg::t_cmd  o_cmd
);

    tq_pkg::t_cmd r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;
    tq_pkg::t_cmd cmd_in;
    logic         wr;
    logic         rd;

    always_comb begin
        cmd_in.now_time        = i_item.now_time;
        cmd_in.expire_time     = i_item.expire_time;
        cmd_in.repeat_interval = i_item.repeat_interval;
        cmd_in.cancel_slot     = i_item.cancel_slot;
        cmd_in.cancel_sequence = i_item.cancel_sequence;
        // unused mode code falls back to cancel
        if (i_item.mode == tq_pkg::OP_TICK) begin
            cmd_in.op = tq_pkg::OP_TICK;
        end else if (i_item.mode == tq_pkg::OP_ADD) begin
            cmd_in.op = tq_pkg::OP_ADD;
        end else begin
            cmd_in.op = tq_pkg::OP_CANCEL;
        end
    end

    assign o_full      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_mem[r_rp];
    assign wr          = i_push && !o_full;
    assign rd          = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) begin
                r_wp <= !r_wp;
            end
            if (rd) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= cmd_in;
        end
    end

endmodule

// ===== rtl/core/tq_outq.sv =====
// ----------------------------------------------------------------------------
// Timer queue result queue
// Two-entry queue that holds results until the consumer pops them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tq_outq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tq_pkg::t_result i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output tq_pkg::t_result o_data
);

    tq_pkg::t_result r_mem [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;
    logic            wr;
    logic            rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) begin
                r_wp <= !r_wp;
            end
            if (rd) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ===== rtl/core/tq_engine.sv =====
// ----------------------------------------------------------------------------
// Timer queue engine
// Executes add, cancel and tick commands on the timer table, one slot a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tq_engine #(
    parameter int NUM_TIMERS = tq_pkg::NUM_TIMERS_DEF,
    parameter int TIME_BITS  = tq_pkg::TIME_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [31:0]     i_min_delay,
    input  logic            i_cmd_valid,
    input  tq_pkg::t_cmd    i_cmd,
    output logic            o_cmd_pop,
    input  logic            i_res_full,
    output logic            o_res_push,
    output tq_pkg::t_result o_res
);

    localparam int SW = $clog2(NUM_TIMERS);
    localparam int DW = (TIME_BITS > 32) ? TIME_BITS : 32;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CANCEL = 3'd1;
    localparam logic [2:0] S_ASCAN  = 3'd2;
    localparam logic [2:0] S_AFIN   = 3'd3;
    localparam logic [2:0] S_TSCAN  = 3'd4;
    localparam logic [2:0] S_TSEL   = 3'd5;
    localparam logic [2:0] S_TDONE  = 3'd6;
    localparam logic [2:0] S_PUSH   = 3'd7;

    typedef logic [TIME_BITS-1:0] t_time;

    logic [2:0]            r_state;
    logic [2:0]            r_ret;
    logic [SW-1:0]         r_idx;
    tq_pkg::t_cmd          r_cmd;
    logic                  r_any;
    t_time                 r_earliest;
    logic                  r_found;
    logic [SW-1:0]         r_best;
    t_time                 r_best_exp;
    logic [NUM_TIMERS-1:0] r_done;
    tq_pkg::t_result       r_res;

    logic [NUM_TIMERS-1:0] r_valid;
    t_time                 r_expiry   [NUM_TIMERS];
    t_time                 r_interval [NUM_TIMERS];
    logic [15:0]           r_seq      [NUM_TIMERS];
    logic [15:0]           r_next_seq;

    t_time                 now_t;
    t_time                 when_t;
    t_time                 iv_t;
    logic [SW-1:0]         rd_addr;
    t_time                 rd_exp;
    t_time                 rd_iv;
    logic [15:0]           rd_seq;
    logic                  rd_valid;
    logic                  last_idx;
    logic                  cancel_hit;
    logic [TIME_BITS:0]    rearm_sum;
    t_time                 rearm_exp;
    t_time                 diff;
    logic [DW-1:0]         diff_ext;
    logic [31:0]           diff_sat;
    logic [31:0]           delay;
    logic                  we_all;
    logic                  we_exp;
    logic [SW-1:0]         wr_addr;
    t_time                 wr_exp;

    function automatic tq_pkg::t_result res_pack(input logic [2:0]  kind,
                                                 input logic [3:0]  slot,
                                                 input logic [15:0] seq,
                                                 input logic        early,
                                                 input logic        hasn,
                                                 input logic [31:0] dly,
                                                 input logic        lst);
        tq_pkg::t_result r;
        r.kind             = kind;
        r.slot             = slot;
        r.sequence_res     = seq;
        r.earliest_changed = early;
        r.has_next         = hasn;
        r.next_delay       = dly;
        r.last             = lst;
        return r;
    endfunction

    assign now_t  = TIME_BITS'(r_cmd.now_time);
    assign when_t = TIME_BITS'(r_cmd.expire_time);
    assign iv_t   = TIME_BITS'(r_cmd.repeat_interval);

    always_comb begin
        if (r_state == S_CANCEL) begin
            rd_addr = SW'(r_cmd.cancel_slot);
        end else if (r_state == S_TSEL) begin
            rd_addr = r_best;
        end else begin
            rd_addr = r_idx;
        end
    end

    assign rd_exp   = r_expiry[rd_addr];
    assign rd_iv    = r_interval[rd_addr];
    assign rd_seq   = r_seq[rd_addr];
    assign rd_valid = r_valid[rd_addr];
    assign last_idx = (r_idx == SW'(NUM_TIMERS - 1));

    assign cancel_hit = (32'(r_cmd.cancel_slot) < NUM_TIMERS) && rd_valid
                        && (rd_seq == r_cmd.cancel_sequence);

    // re-arm at now plus interval, saturate at the top of the time range
    assign rearm_sum = {1'b0, now_t} + {1'b0, rd_iv};
    assign rearm_exp = rearm_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : rearm_sum[TIME_BITS-1:0];

    assign diff     = (r_earliest > now_t) ? (r_earliest - now_t) : '0;
    assign diff_ext = DW'(diff);
    assign diff_sat = (diff_ext > DW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : diff_ext[31:0];

    always_comb begin
        if (!r_any) begin
            delay = 32'd0;
        end else if (diff_sat < i_min_delay) begin
            delay = i_min_delay;
        end else begin
            delay = diff_sat;
        end
    end

    assign we_all  = (r_state == S_AFIN) && r_found;
    assign we_exp  = (r_state == S_TSEL) && r_found && (rd_iv != '0);
    assign wr_addr = we_all ? r_best : rd_addr;
    assign wr_exp  = we_all ? when_t : rearm_exp;

    assign o_cmd_pop  = (r_state == S_IDLE) && i_cmd_valid;
    assign o_res_push = (r_state == S_PUSH) && !i_res_full;
    assign o_res      = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ret      <= S_IDLE;
            r_idx      <= '0;
            r_any      <= 1'b0;
            r_found    <= 1'b0;
            r_done     <= '0;
            r_valid    <= '0;
            r_next_seq <= 16'd0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd   <= i_cmd;
                        r_idx   <= '0;
                        r_any   <= 1'b0;
                        r_found <= 1'b0;
                        r_done  <= '0;
                        if (i_cmd.op == tq_pkg::OP_TICK) begin
                            r_state <= S_TSCAN;
                        end else if (i_cmd.op == tq_pkg::OP_ADD) begin
                            r_state <= S_ASCAN;
                        end else begin
                            r_state <= S_CANCEL;
                        end
                    end
                end
                S_CANCEL: begin
                    if (cancel_hit) begin
                        r_res <= res_pack(tq_pkg::KIND_CANCELLED, 4'd0, 16'd0, 1'b0,
                                          1'b0, 32'd0, 1'b1);
                        r_valid[rd_addr] <= 1'b0;
                    end else begin
                        r_res <= res_pack(tq_pkg::KIND_NO_MATCH, 4'd0, 16'd0, 1'b0,
                                          1'b0, 32'd0, 1'b1);
                    end
                    r_ret   <= S_IDLE;
                    r_state <= S_PUSH;
                end
                S_ASCAN: begin
                    // track earliest armed deadline and lowest free slot
                    if (rd_valid) begin
                        if (!r_any || rd_exp < r_earliest) begin
                            r_earliest <= rd_exp;
                        end
                        r_any <= 1'b1;
                    end else if (!r_found) begin
                        r_found <= 1'b1;
                        r_best  <= r_idx;
                    end
                    r_idx <= r_idx + 1'b1;
                    if (last_idx) begin
                        r_state <= S_AFIN;
                    end
                end
                S_AFIN: begin
                    if (r_found) begin
                        r_res <= res_pack(tq_pkg::KIND_ADDED, 4'(r_best), r_next_seq,
                                          !r_any || (when_t < r_earliest),
                                          1'b0, 32'd0, 1'b1);
                        r_valid[r_best] <= 1'b1;
                        r_next_seq <= r_next_seq + 16'd1;
                    end else begin
                        r_res <= res_pack(tq_pkg::KIND_FULL, 4'd0, 16'd0, 1'b0,
                                          1'b0, 32'd0, 1'b1);
                    end
                    r_ret   <= S_IDLE;
                    r_state <= S_PUSH;
                end
                S_TSCAN: begin
                    if (rd_valid) begin
                        if (!r_any || rd_exp < r_earliest) begin
                            r_earliest <= rd_exp;
                        end
                        r_any <= 1'b1;
                        // earliest due slot not yet emitted in this tick
                        if (!r_done[r_idx] && rd_exp <= now_t
                            && (!r_found || rd_exp < r_best_exp)) begin
                            r_found    <= 1'b1;
                            r_best     <= r_idx;
                            r_best_exp <= rd_exp;
                        end
                    end
                    r_idx <= r_idx + 1'b1;
                    if (last_idx) begin
                        r_state <= S_TSEL;
                    end
                end
                S_TSEL: begin
                    if (r_found) begin
                        r_res <= res_pack(tq_pkg::KIND_EXPIRED, 4'(r_best), rd_seq, 1'b0,
                                          1'b0, 32'd0, 1'b0);
                        r_done[r_best] <= 1'b1;
                        if (rd_iv == '0) begin
                            r_valid[r_best] <= 1'b0;
                        end
                        r_idx   <= '0;
                        r_any   <= 1'b0;
                        r_found <= 1'b0;
                        r_ret   <= S_TSCAN;
                        r_state <= S_PUSH;
                    end else begin
                        r_state <= S_TDONE;
                    end
                end
                S_TDONE: begin
                    r_res <= res_pack(tq_pkg::KIND_TICK_DONE, 4'd0, 16'd0, 1'b0,
                                      r_any, delay, 1'b1);
                    r_ret   <= S_IDLE;
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (!i_res_full) begin
                        r_state <= r_ret;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_all || we_exp) begin
            r_expiry[wr_addr] <= wr_exp;
        end
        if (we_all) begin
            r_interval[wr_addr] <= iv_t;
            r_seq[wr_addr]      <= r_next_seq;
        end
    end

endmodule

// ===== rtl/core/timer_queue_core.sv =====
// Operation: add scans the whole table one slot a cycle; cancel reads only its slot;
//   a tick rescans the table once per expired timer and once more to finish.
// Throughput: one command in the engine at a time; a two-entry command queue and a
//   two-entry result queue let input and output stall on their own.
// Reset: synchronous active low; clears all timers, the sequence counter and both
//   queues, and sets min_delay to 100.
// ----------------------------------------------------------------------------
// Timer queue top level
// Ordered table of one-shot and repeating timers behind queue-style ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module timer_queue_core #(
    parameter int NUM_TIMERS = tq_pkg::NUM_TIMERS_DEF,
    parameter int TIME_BITS  = tq_pkg::TIME_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tq_pkg::t_item   i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output tq_pkg::t_result o_result,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [31:0]     i_cfg_data
);

    logic [31:0]     r_min_delay;
    logic            cmd_valid;
    logic            cmd_pop;
    tq_pkg::t_cmd    cmd;
    logic            res_full;
    logic            res_push;
    tq_pkg::t_result res;
    logic            res_nonlast;

    assign o_cfg_ready = 1'b1;
    assign res_nonlast = !o_empty && !o_result.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_delay <= tq_pkg::MIN_DELAY_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_min_delay <= i_cfg_data;
        end
    end

    tq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_item      (i_item),
        .o_full      (o_full),
        .i_cmd_pop   (cmd_pop),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd)
    );

    tq_engine #(
        .NUM_TIMERS (NUM_TIMERS),
        .TIME_BITS  (TIME_BITS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_min_delay (r_min_delay),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res)
    );

    tq_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (i_pop),
        .o_empty (o_empty),
        .o_data  (o_result)
    );

    `TQ_ASSERT_NEVER(a_res_no_overflow, i_clk, i_rst_n, res_push && res_full)
    `TQ_ASSERT_NEVER(a_cmd_no_underflow, i_clk, i_rst_n, cmd_pop && !cmd_valid)
    `TQ_ASSERT(a_nonlast_is_expired, i_clk, i_rst_n, res_nonlast |-> (o_result.kind == tq_pkg::KIND_EXPIRED))

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// Timer queue testbench
// Drives add, cancel and tick commands through the queue ports, predicts every
// result with a behavioral timer table, and compares results field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int NT = 16;
    localparam int CYCLE_LIMIT = 2_000_000;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_push;
    tq_pkg::t_item   i_item;
    logic            o_full;
    logic            i_pop;
    logic            o_empty;
    tq_pkg::t_result o_result;
    logic            i_cfg_valid;
    logic            o_cfg_ready;
    logic [31:0]     i_cfg_data;

    timer_queue_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_item      (i_item),
        .o_full      (o_full),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // predicted timer table
    logic        tbl_valid [NT];
    logic [31:0] tbl_expiry [NT];
    logic [31:0] tbl_interval [NT];
    logic [15:0] tbl_seq [NT];
    logic [15:0] seq_next;
    logic [31:0] delay_floor;

    tq_pkg::t_result expected_results [$];
    int      error_count;
    int      cycle_count;
    int      send_idle_pct;
    int      recv_idle_pct;
    int      hold_cycles;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        error_count++;
    endtask

    function automatic tq_pkg::t_result make_result(input logic [2:0] kind,
                                                    input logic [3:0] slot,
                                                    input logic [15:0] sq, input logic early,
                                                    input logic hasn, input logic [31:0] dly,
                                                    input logic lst);
        tq_pkg::t_result r;
        r.kind = kind;
        r.slot = slot;
        r.sequence_res = sq;
        r.earliest_changed = early;
        r.has_next = hasn;
        r.next_delay = dly;
        r.last = lst;
        return r;
    endfunction

    task automatic predict_timers(input tq_pkg::t_item it);
        int          free_slot;
        logic        any;
        logic [31:0] earliest;
        int          order [$];
        int          pick;
        logic [32:0] sum;
        logic [31:0] dly;
        free_slot = -1;
        any = 1'b0;
        earliest = '0;
        if (it.mode == tq_pkg::OP_ADD) begin
            for (int i = 0; i < NT; i++) begin
                if (tbl_valid[i]) begin
                    if (!any || tbl_expiry[i] < earliest) earliest = tbl_expiry[i];
                    any = 1'b1;
                end else if (free_slot < 0) begin
                    free_slot = i;
                end
            end
            if (free_slot < 0) begin
                expected_results.push_back(make_result(tq_pkg::KIND_FULL, 4'd0, 16'd0,
                    1'b0, 1'b0, 32'd0, 1'b1));
            end else begin
                tbl_valid[free_slot] = 1'b1;
                tbl_expiry[free_slot] = it.expire_time;
                tbl_interval[free_slot] = it.repeat_interval;
                tbl_seq[free_slot] = seq_next;
                expected_results.push_back(make_result(tq_pkg::KIND_ADDED, 4'(free_slot),
                    seq_next, !any || it.expire_time < earliest, 1'b0, 32'd0, 1'b1));
                seq_next = seq_next + 16'd1;
            end
        end else if (it.mode == tq_pkg::OP_TICK) begin
            for (int i = 0; i < NT; i++)
                if (tbl_valid[i] && tbl_expiry[i] <= it.now_time) order.push_back(i);
            // emit earliest first, lowest slot on ties
            while (order.size() > 0) begin
                pick = 0;
                for (int j = 1; j < order.size(); j++)
                    if (tbl_expiry[order[j]] < tbl_expiry[order[pick]]) pick = j;
                expected_results.push_back(make_result(tq_pkg::KIND_EXPIRED,
                    4'(order[pick]), tbl_seq[order[pick]], 1'b0, 1'b0, 32'd0, 1'b0));
                if (tbl_interval[order[pick]] != 0) begin
                    sum = {1'b0, it.now_time} + {1'b0, tbl_interval[order[pick]]};
                    tbl_expiry[order[pick]] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                end else begin
                    tbl_valid[order[pick]] = 1'b0;
                end
                order.delete(pick);
            end
            for (int i = 0; i < NT; i++) begin
                if (tbl_valid[i] && (!any || tbl_expiry[i] < earliest)) begin
                    earliest = tbl_expiry[i];
                    any = 1'b1;
                end
            end
            dly = '0;
            if (any) begin
                dly = earliest > it.now_time ? earliest - it.now_time : 32'd0;
                if (dly < delay_floor) dly = delay_floor;
            end
            expected_results.push_back(make_result(tq_pkg::KIND_TICK_DONE, 4'd0, 16'd0,
                1'b0, any, dly, 1'b1));
        end else begin
            if (tbl_valid[it.cancel_slot] && tbl_seq[it.cancel_slot] == it.cancel_sequence)
                begin
                tbl_valid[it.cancel_slot] = 1'b0;
                expected_results.push_back(make_result(tq_pkg::KIND_CANCELLED, 4'd0, 16'd0,
                    1'b0, 1'b0, 32'd0, 1'b1));
            end else begin
                expected_results.push_back(make_result(tq_pkg::KIND_NO_MATCH, 4'd0, 16'd0,
                    1'b0, 1'b0, 32'd0, 1'b1));
            end
        end
    endtask

    // push stays high between back-to-back items; drop it only while idling or draining
    task automatic send_item(input tq_pkg::t_item it);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_push <= 1'b0;
            @(posedge i_clk);
        end
        i_push <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        predict_timers(it);
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && i_pop && !o_empty) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with no transaction expected");
            end else begin
                tq_pkg::t_result e;
                e = expected_results.pop_front();
                if (o_result.kind !== e.kind) report_mismatch("kind");
                if (o_result.slot !== e.slot) report_mismatch("slot");
                if (o_result.sequence_res !== e.sequence_res) report_mismatch("sequence_res");
                if (o_result.earliest_changed !== e.earliest_changed)
                    report_mismatch("earliest_changed");
                if (o_result.has_next !== e.has_next) report_mismatch("has_next");
                if (o_result.next_delay !== e.next_delay) report_mismatch("next_delay");
                if (o_result.last !== e.last) report_mismatch("last");
            end
        end
    end

    // receiver: random stalls, plus a long hold-off when requested
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_pop <= 1'b0;
        end else begin
            i_pop <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic drain_results;
        i_push <= 1'b0;
        while (expected_results.size() > 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic write_min_delay(input logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        delay_floor = value;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic tq_pkg::t_item add_item(input logic [31:0] expiry,
                                               input logic [31:0] period);
        tq_pkg::t_item it;
        it = '0;
        it.mode = tq_pkg::OP_ADD;
        it.now_time = $urandom;
        it.expire_time = expiry;
        it.repeat_interval = period;
        it.cancel_slot = 4'($urandom);
        it.cancel_sequence = 16'($urandom);
        return it;
    endfunction

    function automatic tq_pkg::t_item tick_item(input logic [31:0] now);
        tq_pkg::t_item it;
        it = '0;
        it.mode = tq_pkg::OP_TICK;
        it.now_time = now;
        it.expire_time = $urandom;
        it.repeat_interval = $urandom;
        it.cancel_slot = 4'($urandom);
        it.cancel_sequence = 16'($urandom);
        return it;
    endfunction

    function automatic tq_pkg::t_item cancel_item(input logic [1:0] op, input logic [3:0] slot,
                                                  input logic [15:0] sq);
        tq_pkg::t_item it;
        it = '0;
        it.mode = op;
        it.now_time = $urandom;
        it.expire_time = $urandom;
        it.repeat_interval = $urandom;
        it.cancel_slot = slot;
        it.cancel_sequence = sq;
        return it;
    endfunction

    task automatic test_directed;
        send_item(tick_item(32'd0));
        send_item(add_item(32'd500, 32'd0));
        send_item(add_item(32'd500, 32'd250));
        send_item(add_item(32'd200, 32'hFFFF_FFFF));
        send_item(add_item(32'hFFFF_FFFF, 32'd1));
        send_item(add_item(32'd0, 32'd0));
        send_item(cancel_item(tq_pkg::OP_CANCEL, 4'd4, 16'd4));
        send_item(cancel_item(tq_pkg::OP_CANCEL, 4'd4, 16'd4));
        send_item(cancel_item(2'd3, 4'd15, 16'hFFFF));
        send_item(cancel_item(2'd3, 4'd0, 16'd1));
        send_item(tick_item(32'd500));
        send_item(tick_item(32'd1000));
        // fill the table, then overflow it
        for (int i = 0; i < 16; i++) send_item(add_item(32'd10 + i, i[0] ? 32'd0 : 32'd7));
        send_item(tick_item(32'hFFFF_FFFF));
        drain_results();
    endtask

    task automatic test_random(input int count);
        tq_pkg::t_item it;
        int    live;
        int    pick;
        for (int n = 0; n < count; n++) begin
            live = 0;
            for (int i = 0; i < NT; i++) live += int'(tbl_valid[i]);
            pick = $urandom_range(99);
            if (pick < 40 && live < 14) begin
                it = add_item($urandom_range(3) == 0 ? $urandom : $urandom_range(5000),
                              $urandom_range(2) == 0 ? 32'd0 :
                              ($urandom_range(9) == 0 ? $urandom : $urandom_range(800)));
            end else if (pick < 70) begin
                it = tick_item($urandom_range(9) == 0 ? $urandom : $urandom_range(6000));
            end else if (pick < 90) begin
                pick = $urandom_range(NT - 1);
                it = cancel_item(tq_pkg::OP_CANCEL, 4'(pick), tbl_seq[pick]);
            end else begin
                it = cancel_item(2'($urandom_range(2, 3)), 4'($urandom), 16'($urandom));
                if ($urandom_range(1)) it = add_item($urandom, $urandom);
            end
            send_item(it);
        end
        drain_results();
    endtask

    task automatic test_backpressure;
        hold_cycles = 600;
        for (int i = 0; i < 20; i++)
            send_item(i[0] ? tick_item($urandom_range(3000)) :
                             add_item($urandom_range(3000), $urandom_range(300)));
        drain_results();
    endtask

    initial begin
        error_count = 0;
        cycle_count = 0;
        hold_cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n = 1'b0;
        i_push = 1'b0;
        i_item = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        for (int i = 0; i < NT; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_expiry[i] = '0;
            tbl_interval[i] = '0;
            tbl_seq[i] = '0;
        end
        seq_next = '0;
        delay_floor = tq_pkg::MIN_DELAY_RST;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 22;
        recv_idle_pct = 78;
        test_directed();
        test_backpressure();
        write_min_delay(32'd0);
        test_random(140);

        send_idle_pct = 78;
        recv_idle_pct = 22;
        write_min_delay(32'hFFFF_FFFF);
        test_random(60);
        write_min_delay($urandom_range(2000));
        test_random(80);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_min_delay(tq_pkg::MIN_DELAY_RST);
        test_random(120);

        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
